// File: src/gaa_pkg.sv
// Shared types and constants for the gas alarm annunciator.
`default_nettype none

package gaa_pkg;

   localparam int PERIOD_BITS    = 16;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int THR_MIN_BITS   = 10;
   localparam int CHANNELS       = 3;

   localparam int CH_AIR     = 0;
   localparam int CH_CO      = 1;
   localparam int CH_METHANE = 2;

   localparam int THRESHOLD_RESET   = 660;
   localparam int FAST_HALF_RESET   = 200;
   localparam int SLOW_HALF_RESET   = 1000;
   localparam int SHORT_BEEP_RESET  = 100;
   localparam int LONG_PAUSE_RESET  = 500;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_THRESHOLD_AIR     = 3'd0,
      CSR_THRESHOLD_CO      = 3'd1,
      CSR_THRESHOLD_METHANE = 3'd2,
      CSR_FAST_HALF_PERIOD  = 3'd3,
      CSR_SLOW_HALF_PERIOD  = 3'd4,
      CSR_SHORT_BEEP_TICKS  = 3'd5,
      CSR_LONG_PAUSE_TICKS  = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      CO_START = 3'd0,
      CO_BEEP1 = 3'd1,
      CO_GAP1  = 3'd2,
      CO_BEEP2 = 3'd3,
      CO_PAUSE = 3'd4
   } co_step_type;

endpackage

`default_nettype wire

// File: src/gaa_if.sv
// Request and response channel interfaces of the gas alarm annunciator.
`default_nettype none

interface gaa_req_if #(
   parameter int SAMPLE_BITS = 10
);
   logic                   valid;
   logic                   ready;
   logic                   sample_valid;
   logic [SAMPLE_BITS-1:0] air_sample;
   logic [SAMPLE_BITS-1:0] co_sample;
   logic [SAMPLE_BITS-1:0] methane_sample;
   logic                   air_button;
   logic                   co_button;
   logic                   methane_button;

   modport source (
      output valid, sample_valid, air_sample, co_sample, methane_sample,
             air_button, co_button, methane_button,
      input  ready
   );
   modport sink (
      input  valid, sample_valid, air_sample, co_sample, methane_sample,
             air_button, co_button, methane_button,
      output ready
   );
endinterface

interface gaa_rsp_if;
   logic valid;
   logic ready;
   logic air_alarm;
   logic co_alarm;
   logic methane_alarm;
   logic air_enabled;
   logic co_enabled;
   logic methane_enabled;

   modport source (
      output valid, air_alarm, co_alarm, methane_alarm,
             air_enabled, co_enabled, methane_enabled,
      input  ready
   );
   modport sink (
      input  valid, air_alarm, co_alarm, methane_alarm,
             air_enabled, co_enabled, methane_enabled,
      output ready
   );
endinterface

`default_nettype wire

// File: src/gas_alarm_annunciator.sv
// Gas alarm annunciator top level: button enables, thresholds and alarm patterns.
// Latency: a result is valid in the cycle after its tick item is accepted.
// Throughput: one item per cycle unless stalled; channel state registers double as result.
// A new item is accepted while the pending result is taken in the same cycle.
// Reset (synchronous, active high): all channels enabled, alarms low, readings and
// counters zero, thresholds 660, periods 200/1000, beep 100, pause 500.
`default_nettype none

module gas_alarm_annunciator
   import gaa_pkg::*;
#(
   parameter int SAMPLE_BITS = 10,
   parameter int TIMER_BITS  = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   gaa_req_if.sink                        req_chan,
   gaa_rsp_if.source                      rsp_chan,
   input  wire logic                      csr_write,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int THR_BITS = (SAMPLE_BITS > THR_MIN_BITS) ? SAMPLE_BITS : THR_MIN_BITS;
   localparam int CMP_BITS = (TIMER_BITS > PERIOD_BITS) ? TIMER_BITS : PERIOD_BITS;
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

   // configuration registers
   logic [THR_BITS-1:0]    thr_ff [CHANNELS];
   logic [PERIOD_BITS-1:0] fast_half_ff;
   logic [PERIOD_BITS-1:0] slow_half_ff;
   logic [PERIOD_BITS-1:0] short_beep_ff;
   logic [PERIOD_BITS-1:0] long_pause_ff;

   // channel state
   logic [SAMPLE_BITS-1:0] reading_ff  [CHANNELS];
   logic [SAMPLE_BITS-1:0] reading_in  [CHANNELS];
   logic [TIMER_BITS-1:0]  elapsed_ff  [CHANNELS];
   logic [TIMER_BITS-1:0]  elapsed_in  [CHANNELS];
   logic [TIMER_BITS-1:0]  elapsed_inc [CHANNELS];
   logic [CHANNELS-1:0]    enable_ff, enable_in;
   logic [CHANNELS-1:0]    button_ff, button_in;
   logic [CHANNELS-1:0]    alarm_ff, alarm_in;
   logic [CHANNELS-1:0]    alarm_pre;
   logic [CHANNELS-1:0]    press;
   logic [CHANNELS-1:0]    above;
   co_step_type            co_step_ff, co_step_in, co_step_pre;
   logic                   co_clear;
   logic                   co_alarm_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   accept;

   logic [SAMPLE_BITS-1:0] sample_bus [CHANNELS];
   logic [CMP_BITS-1:0]    co_wait;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;

   assign sample_bus[CH_AIR]     = req_chan.air_sample;
   assign sample_bus[CH_CO]      = req_chan.co_sample;
   assign sample_bus[CH_METHANE] = req_chan.methane_sample;

   assign button_in = {req_chan.methane_button, req_chan.co_button, req_chan.air_button};

   // buttons, sample capture and timer advance
   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         press[i]       = button_ff[i] && !button_in[i];
         enable_in[i]   = enable_ff[i] ^ press[i];
         alarm_pre[i]   = (press[i] && !enable_in[i]) ? 1'b0 : alarm_ff[i];
         reading_in[i]  = req_chan.sample_valid ? sample_bus[i] : reading_ff[i];
         elapsed_inc[i] = (elapsed_ff[i] == TIMER_MAX) ? elapsed_ff[i]
                                                        : elapsed_ff[i] + 1'b1;
         above[i]       = THR_BITS'(reading_in[i]) > thr_ff[i];
      end
      co_step_pre = (press[CH_CO] && !enable_in[CH_CO]) ? CO_START : co_step_ff;
   end

   // CO sequence next step
   always_comb begin
      co_step_in = co_step_pre;
      co_clear   = 1'b0;
      co_wait    = CMP_BITS'(short_beep_ff);
      if (co_step_pre == CO_PAUSE) begin
         co_wait = CMP_BITS'(long_pause_ff);
      end
      if (enable_in[CH_CO]) begin
         if (!above[CH_CO]) begin
            co_step_in = CO_START;
         end else begin
            unique case (co_step_pre)
               CO_BEEP1: begin
                  if (CMP_BITS'(elapsed_inc[CH_CO]) >= co_wait) begin
                     co_step_in = CO_GAP1;
                     co_clear   = 1'b1;
                  end
               end
               CO_GAP1: begin
                  if (CMP_BITS'(elapsed_inc[CH_CO]) >= co_wait) begin
                     co_step_in = CO_BEEP2;
                     co_clear   = 1'b1;
                  end
               end
               CO_BEEP2: begin
                  if (CMP_BITS'(elapsed_inc[CH_CO]) >= co_wait) begin
                     co_step_in = CO_PAUSE;
                     co_clear   = 1'b1;
                  end
               end
               CO_PAUSE: begin
                  if (CMP_BITS'(elapsed_inc[CH_CO]) >= co_wait) begin
                     co_step_in = CO_START;
                  end
               end
               default: begin
                  co_step_in = CO_BEEP1;
                  co_clear   = 1'b1;
               end
            endcase
         end
      end
   end

   // CO alarm drive
   always_comb begin
      co_alarm_in = alarm_pre[CH_CO];
      if (enable_in[CH_CO]) begin
         if (!above[CH_CO]) begin
            co_alarm_in = 1'b0;
         end else if (co_clear) begin
            co_alarm_in = (co_step_in == CO_BEEP1) || (co_step_in == CO_BEEP2);
         end
      end
   end

   // air and methane togglers, timer clears
   always_comb begin
      alarm_in   = alarm_pre;
      elapsed_in = elapsed_inc;
      if (enable_in[CH_AIR]) begin
         if (!above[CH_AIR]) begin
            alarm_in[CH_AIR] = 1'b0;
         end else if (CMP_BITS'(elapsed_inc[CH_AIR]) >= CMP_BITS'(fast_half_ff)) begin
            alarm_in[CH_AIR]   = !alarm_pre[CH_AIR];
            elapsed_in[CH_AIR] = '0;
         end
      end
      if (enable_in[CH_METHANE]) begin
         if (!above[CH_METHANE]) begin
            alarm_in[CH_METHANE] = 1'b0;
         end else if (CMP_BITS'(elapsed_inc[CH_METHANE]) >= CMP_BITS'(slow_half_ff)) begin
            alarm_in[CH_METHANE]   = !alarm_pre[CH_METHANE];
            elapsed_in[CH_METHANE] = '0;
         end
      end
      alarm_in[CH_CO] = co_alarm_in;
      if (co_clear) begin
         elapsed_in[CH_CO] = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         enable_ff    <= '1;
         button_ff    <= '1;
         alarm_ff     <= '0;
         co_step_ff   <= CO_START;
         for (int i = 0; i < CHANNELS; i++) begin
            reading_ff[i] <= '0;
            elapsed_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            enable_ff  <= enable_in;
            button_ff  <= button_in;
            alarm_ff   <= alarm_in;
            co_step_ff <= co_step_in;
            reading_ff <= reading_in;
            elapsed_ff <= elapsed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            thr_ff[i] <= THR_BITS'(THRESHOLD_RESET);
         end
         fast_half_ff  <= PERIOD_BITS'(FAST_HALF_RESET);
         slow_half_ff  <= PERIOD_BITS'(SLOW_HALF_RESET);
         short_beep_ff <= PERIOD_BITS'(SHORT_BEEP_RESET);
         long_pause_ff <= PERIOD_BITS'(LONG_PAUSE_RESET);
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_THRESHOLD_AIR:     thr_ff[CH_AIR]     <= THR_BITS'(csr_data[SAMPLE_BITS-1:0]);
            CSR_THRESHOLD_CO:      thr_ff[CH_CO]      <= THR_BITS'(csr_data[SAMPLE_BITS-1:0]);
            CSR_THRESHOLD_METHANE: thr_ff[CH_METHANE] <= THR_BITS'(csr_data[SAMPLE_BITS-1:0]);
            CSR_FAST_HALF_PERIOD:  fast_half_ff       <= csr_data;
            CSR_SLOW_HALF_PERIOD:  slow_half_ff       <= csr_data;
            CSR_SHORT_BEEP_TICKS:  short_beep_ff      <= csr_data;
            CSR_LONG_PAUSE_TICKS:  long_pause_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.air_alarm       = alarm_ff[CH_AIR];
   assign rsp_chan.co_alarm        = alarm_ff[CH_CO];
   assign rsp_chan.methane_alarm   = alarm_ff[CH_METHANE];
   assign rsp_chan.air_enabled     = enable_ff[CH_AIR];
   assign rsp_chan.co_enabled      = enable_ff[CH_CO];
   assign rsp_chan.methane_enabled = enable_ff[CH_METHANE];

   a_disabled_silent: assert property (@(posedge clock) disable iff (reset)
      (alarm_ff & ~enable_ff) == '0)
      else $error("alarm driven on a disabled channel");

   a_co_step_enabled: assert property (@(posedge clock) disable iff (reset)
      (co_step_ff != CO_START) |-> enable_ff[CH_CO])
      else $error("CO sequence running while CO disabled");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_chan.valid)
      else $error("accepted item produced no result");

   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> ($stable(alarm_ff) && $stable(enable_ff)))
      else $error("channel state changed while result stalled");

endmodule

`default_nettype wire
